// ===== hw/rtl/cqs_pkg.sv =====
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types for the circular queue with search: command and status codes,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package cqs_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cqs_cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELETED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_SEARCH   = 3'd4
  } cqs_status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_DEL   = 3'd1,
    S_SCAN  = 3'd2,
    S_DRAIN = 3'd3,
    S_FIN   = 3'd4
  } cqs_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // beat accepted this cycle
    logic del_done;  // head read data is ready, retire the delete
    logic scan_rd;   // read the next occupied entry
    logic fin;       // emit the closing search result
  } cqs_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic scan_last; // the current scan read is the final one
  } cqs_stat_t;

endpackage

// ===== hw/rtl/cqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqs_ctrl
// Sequencer for the queue: decodes accepted beats, walks search scans.
// ----------------------------------------------------------------------------
module cqs_ctrl import cqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] command_i,
  input  cqs_stat_t  stat_i,
  output logic       busy_o,
  output cqs_ctrl_t  ctrl_o
);

  cqs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
        if (start_i && !stat_i.empty) begin
          case (command_i)
            CMD_DELETE: state_d = S_DEL;
            CMD_SEARCH: state_d = S_SCAN;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_DEL: begin
        ctrl_o.del_done = 1'b1;
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
        if (stat_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        ctrl_o.fin = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_busy_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> busy_o)
    else $error("busy low outside idle");

  a_scan_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && stat_i.scan_last) |=> (state_q == S_DRAIN))
    else $error("scan did not end after last read");

  a_fin_follows_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> ctrl_o.fin)
    else $error("search not closed after drain");

endmodule

// ===== hw/rtl/cqs_dp.sv =====
// ----------------------------------------------------------------------------
// cqs_dp
// Queue datapath: storage memory, head/tail/count, scan pipeline, result regs.
// ----------------------------------------------------------------------------
module cqs_dp import cqs_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cqs_ctrl_t           ctrl_i,
  input  logic [1:0]          command_i,
  input  logic signed [31:0]  value_i,
  output cqs_stat_t           stat_o,
  output logic                result_valid_o,
  output logic [2:0]          status_o,
  output logic                found_o,
  output logic signed [31:0]  data_o,
  output logic [CW-1:0]       slot_o,
  output logic                last_o
);

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    nxt = (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_q;
  logic signed [31:0] value_q;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CW-1:0] count_q, count_d, rem_q, rem_d;
  logic [CW-1:0] rd_slot_q, pend_slot_q, pend_slot_d;
  logic          rd_vld_q, pend_q, pend_d;

  logic          res_valid_d, res_valid_q;
  logic [2:0]    status_d, status_q;
  logic          found_d, found_q, last_d, last_q;
  logic signed [31:0] data_d, data_q;
  logic [CW-1:0] slot_d, slot_q;

  logic          full, empty, wr_en, rd_en, match;
  logic [AW-1:0] rd_addr;

  assign full  = (count_q == FullCnt);
  assign empty = (count_q == '0);
  assign wr_en = ctrl_i.load && (command_i == CMD_INSERT) && !full;
  assign rd_en = ctrl_i.scan_rd || (ctrl_i.load && (command_i == CMD_DELETE));
  assign rd_addr = ctrl_i.scan_rd ? ptr_q : head_q;
  assign match = rd_vld_q && (rd_data_q == value_q);

  assign stat_o.empty     = empty;
  assign stat_o.scan_last = (rem_q == CW'(1));

  // storage, single write port and single registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[tail_q] <= value_i;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) value_q <= value_i;
    if (ctrl_i.scan_rd) rd_slot_q <= CW'(ptr_q) + CW'(1);
    pend_slot_q <= pend_slot_d;
    status_q    <= status_d;
    found_q     <= found_d;
    data_q      <= data_d;
    slot_q      <= slot_d;
    last_q      <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      rem_q       <= '0;
      rd_vld_q    <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      rem_q       <= rem_d;
      rd_vld_q    <= ctrl_i.scan_rd;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    res_valid_d = 1'b0;
    status_d    = ST_INSERTED;
    found_d     = 1'b0;
    data_d      = '0;
    slot_d      = '0;
    last_d      = 1'b0;

    if (ctrl_i.load) begin
      case (command_i)
        CMD_INSERT: begin
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_INSERTED;
            tail_d   = nxt(tail_q);
            count_d  = count_q + CW'(1);
          end
        end
        CMD_DELETE: begin
          if (empty) begin
            res_valid_d = 1'b1;
            status_d    = ST_EMPTY;
            last_d      = 1'b1;
          end
        end
        CMD_SEARCH: begin
          if (empty) begin
            res_valid_d = 1'b1;
            status_d    = ST_SEARCH;
            last_d      = 1'b1;
          end else begin
            ptr_d  = head_q;
            rem_d  = count_q;
            pend_d = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (ctrl_i.del_done) begin
      res_valid_d = 1'b1;
      status_d    = ST_DELETED;
      data_d      = rd_data_q;
      last_d      = 1'b1;
      count_d     = count_q - CW'(1);
      if (count_q == CW'(1)) begin
        head_d = '0;
        tail_d = '0;
      end else begin
        head_d = nxt(head_q);
      end
    end

    if (ctrl_i.scan_rd) begin
      ptr_d = nxt(ptr_q);
      rem_d = rem_q - CW'(1);
    end

    // a match is held back one hit so the final one can carry last
    if (match) begin
      if (pend_q) begin
        res_valid_d = 1'b1;
        status_d    = ST_SEARCH;
        found_d     = 1'b1;
        slot_d      = pend_slot_q;
      end
      pend_d      = 1'b1;
      pend_slot_d = rd_slot_q;
    end

    if (ctrl_i.fin) begin
      res_valid_d = 1'b1;
      status_d    = ST_SEARCH;
      found_d     = pend_q;
      slot_d      = pend_q ? pend_slot_q : '0;
      last_d      = 1'b1;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign data_o         = data_q;
  assign slot_o         = slot_q;
  assign last_o         = last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("occupancy above depth");

  a_empty_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with stray pointers");

  a_del_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.del_done |-> !empty)
    else $error("delete retired on empty queue");

  a_fin_no_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fin |-> !rd_vld_q)
    else $error("search closed with a compare in flight");

endmodule

// ===== hw/rtl/circular_queue_with_search_core.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_search_core
// Fixed-depth ring buffer of signed 32-bit values with insert, delete-oldest
// and search in queue order (one result per match, last flag on the final).
// ----------------------------------------------------------------------------
// Insert, insert-when-full, delete-when-empty and search of an empty queue
//   give their result in the cycle after the accepting edge; busy stays low,
//   so such beats go back to back. Delete registers its result from S_DEL.
//   Search holds busy through S_SCAN, S_DRAIN and S_FIN; hits stream out
//   while scanning, the closing result is registered from S_FIN.
// Throughput is set by the single read port of the storage memory: one
//   entry read per cycle during a scan. The receiver cannot stall.
// Reset (rst_ni low, async) empties the queue: head, tail, count to zero.
//   Storage contents are not cleared; only occupied entries reach a result.
// ----------------------------------------------------------------------------
module circular_queue_with_search_core import cqs_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command side: a beat is taken when start is high and busy is low
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        command_i,
  input  logic signed [31:0]                value_i,
  // result side: one beat per cycle of result_valid_o, no backpressure
  output logic                              result_valid_o,
  output logic [2:0]                        status_o,
  output logic                              found_o,
  output logic signed [31:0]                data_o,
  output logic [$clog2(DEPTH + 1)-1:0]      slot_o,
  output logic                              last_o
);

  cqs_ctrl_t ctrl;
  cqs_stat_t stat;

  // sequencer: decides when the datapath loads, retires a delete, scans
  cqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .busy_o    (busy_o),
    .ctrl_o    (ctrl)
  );

  // storage, pointers, scan compare and the result register
  cqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .command_i      (command_i),
    .value_i        (value_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .data_o         (data_o),
    .slot_o         (slot_o),
    .last_o         (last_o)
  );

  // last only ever rides on a result beat
  a_last_marks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o)
    else $error("last flag outside a result beat");

  a_busy_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !ctrl.load)
    else $error("beat loaded while busy");

  a_result_while_idle_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fin |=> (result_valid_o && last_o))
    else $error("search finish produced no closing beat");

endmodule
